[hw/rtl/psu_pkg.sv]
// ----------------------------------------------------------------------------
// psu_pkg
// Shared widths, codes and stage types of the PNG scanline unfilter.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

  // Line store and pixel geometry
  localparam int unsigned MaxRowBytes   = 8192;
  localparam int unsigned MaxPixelBytes = 8;
  localparam int unsigned RowAw         = $clog2(MaxRowBytes);
  localparam int unsigned LenW          = 14;
  localparam int unsigned BppW          = 4;
  localparam int unsigned SlotW         = $clog2(MaxPixelBytes);
  localparam int unsigned ByteW         = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 14;
  localparam logic [CfgIdxW-1:0] CfgBpp      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRowBytes = CfgIdxW'(1);

  // Filter type codes
  localparam logic [ByteW-1:0] FiltNone  = 8'd0;
  localparam logic [ByteW-1:0] FiltSub   = 8'd1;
  localparam logic [ByteW-1:0] FiltUp    = 8'd2;
  localparam logic [ByteW-1:0] FiltAvg   = 8'd3;
  localparam logic [ByteW-1:0] FiltPaeth = 8'd4;

  // One data beat handed from row tracking to reconstruction
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic [RowAw-1:0] col;
    logic [SlotW-1:0] slot;
    logic             has_left;
    logic             first_row;
    logic [ByteW-1:0] filt;
    logic             last;
    logic             bad;
  } item_t;

  // Line store write-back
  typedef struct packed {
    logic             en;
    logic [RowAw-1:0] addr;
    logic [ByteW-1:0] data;
  } wr_t;

endpackage

`default_nettype wire

[hw/rtl/psu_ram.sv]
// ----------------------------------------------------------------------------
// psu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/psu_ctrl.sv]
// ----------------------------------------------------------------------------
// psu_ctrl
// Row tracking: configuration registers, filter byte latch, column and
// pixel slot counters, and the line store read issue.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [psu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [psu_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic [psu_pkg::ByteW-1:0]     in_byte_i,
  input  wire logic                          first_of_image_i,
  output      psu_pkg::item_t                item_o,
  output      logic                          rd_en_o,
  output      logic [psu_pkg::RowAw-1:0]     rd_addr_o
);

  logic [psu_pkg::BppW-1:0]  bpp_q, bpp_d;
  logic [psu_pkg::LenW-1:0]  len_q, len_d;
  logic [psu_pkg::BppW-1:0]  bpp_eff;
  logic [psu_pkg::LenW-1:0]  len_eff;
  logic                      wait_filt_q, wait_filt_d;
  logic [psu_pkg::RowAw-1:0] col_q, col_d;
  logic [psu_pkg::ByteW-1:0] filt_q, filt_d;
  logic                      first_row_q, first_row_d;
  logic                      err_q, err_d;
  logic [psu_pkg::SlotW-1:0] cnt_q [psu_pkg::MaxPixelBytes];
  logic [psu_pkg::SlotW-1:0] cnt_d [psu_pkg::MaxPixelBytes];
  logic                      accept;
  logic                      filt_beat;
  logic                      data_beat;
  logic                      last;
  logic [psu_pkg::BppW-1:0]  bpp_m1;

  // Configuration writes
  always_comb begin
    bpp_d = bpp_q;
    len_d = len_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        psu_pkg::CfgBpp:      bpp_d = cfg_data_i[psu_pkg::BppW-1:0];
        psu_pkg::CfgRowBytes: len_d = cfg_data_i[psu_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers to the supported range
  always_comb begin
    bpp_eff = bpp_q;
    if (bpp_q == '0) begin
      bpp_eff = psu_pkg::BppW'(1);
    end else if (bpp_q > psu_pkg::BppW'(psu_pkg::MaxPixelBytes)) begin
      bpp_eff = psu_pkg::BppW'(psu_pkg::MaxPixelBytes);
    end
    len_eff = len_q;
    if (len_q == '0) begin
      len_eff = psu_pkg::LenW'(1);
    end else if (len_q > psu_pkg::LenW'(psu_pkg::MaxRowBytes)) begin
      len_eff = psu_pkg::LenW'(psu_pkg::MaxRowBytes);
    end
  end

  assign accept    = in_valid_i && in_ready_i;
  assign filt_beat = accept && (first_of_image_i || wait_filt_q);
  assign data_beat = accept && !(first_of_image_i || wait_filt_q);
  assign last      = ({1'b0, col_q} + psu_pkg::LenW'(1)) >= len_eff;
  assign bpp_m1    = bpp_eff - psu_pkg::BppW'(1);

  // Row state: latch filter type, advance column, close the row
  always_comb begin
    wait_filt_d = wait_filt_q;
    col_d       = col_q;
    filt_d      = filt_q;
    first_row_d = first_row_q;
    err_d       = err_q;
    if (filt_beat) begin
      wait_filt_d = 1'b0;
      col_d       = '0;
      filt_d      = in_byte_i;
      first_row_d = first_of_image_i ? 1'b1 : first_row_q;
      err_d       = (first_of_image_i ? 1'b0 : err_q) || (in_byte_i > psu_pkg::FiltPaeth);
    end else if (data_beat) begin
      if (last) begin
        wait_filt_d = 1'b1;
        first_row_d = 1'b0;
      end else begin
        col_d = col_q + psu_pkg::RowAw'(1);
      end
    end
  end

  // One wrapping counter per possible pixel size gives column mod size
  always_comb begin
    for (int i = 0; i < psu_pkg::MaxPixelBytes; i++) begin
      cnt_d[i] = cnt_q[i];
      if (filt_beat) begin
        cnt_d[i] = '0;
      end else if (data_beat) begin
        cnt_d[i] = (cnt_q[i] == psu_pkg::SlotW'(i)) ? '0 : cnt_q[i] + psu_pkg::SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q       <= psu_pkg::BppW'(1);
      len_q       <= psu_pkg::LenW'(1);
      wait_filt_q <= 1'b1;
      col_q       <= '0;
      filt_q      <= '0;
      first_row_q <= 1'b1;
      err_q       <= 1'b0;
      for (int i = 0; i < psu_pkg::MaxPixelBytes; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      bpp_q       <= bpp_d;
      len_q       <= len_d;
      wait_filt_q <= wait_filt_d;
      col_q       <= col_d;
      filt_q      <= filt_d;
      first_row_q <= first_row_d;
      err_q       <= err_d;
      for (int i = 0; i < psu_pkg::MaxPixelBytes; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  // Hand the data beat on and read the byte above it
  always_comb begin
    item_o.valid     = data_beat;
    item_o.data      = in_byte_i;
    item_o.col       = col_q;
    item_o.slot      = cnt_q[bpp_m1[psu_pkg::SlotW-1:0]];
    item_o.has_left  = {1'b0, col_q} >= psu_pkg::LenW'(bpp_eff);
    item_o.first_row = first_row_q;
    item_o.filt      = filt_q;
    item_o.last      = last;
    item_o.bad       = err_q;
  end

  assign rd_en_o   = data_beat;
  assign rd_addr_o = col_q;

endmodule

`default_nettype wire

[hw/rtl/psu_recon.sv]
// ----------------------------------------------------------------------------
// psu_recon
// Reconstruction stage: applies the row's predictor to each data beat, keeps
// the pixel history, writes the line store back and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_recon (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire psu_pkg::item_t            item_i,
  input  wire logic [psu_pkg::ByteW-1:0] above_i,
  output      logic                      free_o,
  output      psu_pkg::wr_t              wr_o,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      logic [psu_pkg::ByteW-1:0] out_byte_o,
  output      logic                      row_end_o,
  output      logic                      bad_filter_o
);

  psu_pkg::item_t            s1_q;
  logic                      s1_valid_q, s1_valid_d;
  logic                      adv;
  logic [psu_pkg::ByteW-1:0] left_q [psu_pkg::MaxPixelBytes];
  logic [psu_pkg::ByteW-1:0] upl_q  [psu_pkg::MaxPixelBytes];
  logic [psu_pkg::ByteW-1:0] a, b, c, pred, v;
  logic [psu_pkg::ByteW:0]   avg_sum;
  logic signed [9:0]         pa, pb, pc;
  logic [9:0]                da, db, dc;
  logic                      out_valid_q, out_valid_d;
  logic [psu_pkg::ByteW-1:0] out_byte_q;
  logic                      row_end_q;
  logic                      bad_q;

  // Advance when the result register is empty or being drained
  assign adv    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign free_o = !s1_valid_q || adv;

  // Neighbor bytes: left, above, above-left
  always_comb begin
    a = s1_q.has_left ? left_q[s1_q.slot] : '0;
    b = s1_q.first_row ? '0 : above_i;
    c = (!s1_q.first_row && s1_q.has_left) ? upl_q[s1_q.slot] : '0;
  end

  // Paeth distances from the estimate a + b - c
  always_comb begin
    pa = $signed({2'b00, b}) - $signed({2'b00, c});
    pb = $signed({2'b00, a}) - $signed({2'b00, c});
    pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    da = (pa < 0) ? 10'(-pa) : 10'(pa);
    db = (pb < 0) ? 10'(-pb) : 10'(pb);
    dc = (pc < 0) ? 10'(-pc) : 10'(pc);
  end

  // Predictor select and modulo-256 add
  always_comb begin
    avg_sum = {1'b0, a} + {1'b0, b};
    case (s1_q.filt)
      psu_pkg::FiltSub:   pred = a;
      psu_pkg::FiltUp:    pred = b;
      psu_pkg::FiltAvg:   pred = avg_sum[psu_pkg::ByteW:1];
      psu_pkg::FiltPaeth: begin
        if (da <= db && da <= dc) begin
          pred = a;
        end else if (db <= dc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:            pred = '0;
    endcase
    v = s1_q.data + pred;
  end

  // Stage and result valids
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (item_i.valid) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the stage on a data beat
  always_ff @(posedge clk_i) begin
    if (item_i.valid) begin
      s1_q <= item_i;
    end
  end

  // Pixel history, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < psu_pkg::MaxPixelBytes; i++) begin
        left_q[i] <= '0;
        upl_q[i]  <= '0;
      end
    end else if (adv) begin
      left_q[s1_q.slot] <= v;
      upl_q[s1_q.slot]  <= b;
    end
  end

  // Result beat
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= v;
      row_end_q  <= s1_q.last;
      bad_q      <= s1_q.bad;
    end
  end

  // Write the reconstructed byte back as the next row's above byte
  always_comb begin
    wr_o.en   = adv;
    wr_o.addr = s1_q.col;
    wr_o.data = v;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign row_end_o    = row_end_q;
  assign bad_filter_o = bad_q;

endmodule

`default_nettype wire

[hw/rtl/png_scanline_unfilter.sv]
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth) over an
// inflated byte stream, with a previous-row line store.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   cfg     | in        | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/ready_o   | in_byte_i, first_of_image_i
//   out     | out       | out_valid_o/ready_i  | out_byte_o, row_end_o,
//           |           |                      | bad_filter_o
//
// One byte per cycle sustained while the result beat is taken. A data beat
// reads the line store on its accept cycle, is held in the reconstruction
// stage register and moves on to the result register when that is empty or
// being drained; a filter byte gives no result beat. The line store port (one
// read, one write per cycle) sets that rate. Reset clears control and pixel
// history; the line store needs no clearing pass. A stalled result beat stops
// the reconstruction stage and then the input; the filter byte between rows
// keeps a line store read behind the write of the same column.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [psu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [psu_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [psu_pkg::ByteW-1:0]     in_byte_i,
  input  wire logic                          first_of_image_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [psu_pkg::ByteW-1:0]     out_byte_o,
  output      logic                          row_end_o,
  output      logic                          bad_filter_o
);

  psu_pkg::item_t            item;
  psu_pkg::wr_t              wr;
  logic                      rd_en;
  logic [psu_pkg::RowAw-1:0] rd_addr;
  logic [psu_pkg::ByteW-1:0] above;
  logic                      free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = free;

  // Row tracking and read issue
  psu_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (free),
    .in_byte_i        (in_byte_i),
    .first_of_image_i (first_of_image_i),
    .item_o           (item),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr)
  );

  // Previous-row line store
  psu_ram #(
    .Width (psu_pkg::ByteW),
    .Depth (psu_pkg::MaxRowBytes)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (above)
  );

  // Reconstruction and result register
  psu_recon u_recon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .above_i      (above),
    .free_o       (free),
    .wr_o         (wr),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .row_end_o    (row_end_o),
    .bad_filter_o (bad_filter_o)
  );

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the PNG scanline unfilter with filtered rows and checks every
// reconstructed byte against a predictor of the five PNG filter types. Covers
// each filter type, unknown filter types, register limits, mid-row register
// changes, a long row with the row length register above its maximum, output
// back-pressure and a random stream of rows with random pacing on both sides.
// ----------------------------------------------------------------------------

module testbench;

  import psu_pkg::*;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned RandomItems  = 1000;
  localparam int unsigned LongRowBytes = 200;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 300;

  // Unknown filter type codes used on purpose
  localparam logic [ByteW-1:0] FiltBadLow = 8'd5;
  localparam logic [ByteW-1:0] FiltBadTop = 8'hFF;

  typedef enum logic [1:0] {RxFree, RxCoin, RxComb, RxSlow} rx_mode_e;

  typedef struct packed {
    logic [ByteW-1:0] pixel;
    logic             row_end;
    logic             bad_filter;
  } pixel_beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ByteW-1:0]    in_byte_i;
  logic                first_of_image_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [ByteW-1:0]    out_byte_o;
  logic                row_end_o;
  logic                bad_filter_o;

  // Reconstruction state mirrored by the predictor
  logic [ByteW-1:0] prev_row  [MaxRowBytes];
  logic [ByteW-1:0] left_px   [MaxPixelBytes];
  logic [ByteW-1:0] upleft_px [MaxPixelBytes];
  int unsigned      col_pos;
  int unsigned      prev_row_valid;
  logic [ByteW-1:0] cur_filter;
  logic             top_row;
  logic             filter_err;
  logic [BppW-1:0]  reg_bpp;
  logic [LenW-1:0]  reg_len;

  pixel_beat_t pixels_due [$];
  pixel_beat_t beat_due;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned burst_left;

  bit          hold_req;
  int unsigned hold_left;
  rx_mode_e    rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_tick;

  png_scanline_unfilter DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .first_of_image_i (first_of_image_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .row_end_o        (row_end_o),
    .bad_filter_o     (bad_filter_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic logic [ByteW-1:0] paeth_choice(input logic [ByteW-1:0] a,
                                                    input logic [ByteW-1:0] b,
                                                    input logic [ByteW-1:0] c);
    int ia, ib, ic, est, da, db, dc;
    ia  = int'(a);
    ib  = int'(b);
    ic  = int'(c);
    est = ia + ib - ic;
    da  = (est > ia) ? est - ia : ia - est;
    db  = (est > ib) ? est - ib : ib - est;
    dc  = (est > ic) ? est - ic : ic - est;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // True when this beat would read a line store column never written
  function automatic bit reads_unwritten(input logic sof);
    int unsigned x;
    if (sof || col_pos == 0 || top_row) return 1'b0;
    x = col_pos - 1;
    if (x >= MaxRowBytes) x = MaxRowBytes - 1;
    return x >= prev_row_valid;
  endfunction

  // Advance the mirrored state by one accepted input beat
  task automatic predict_byte(input logic [ByteW-1:0] din, input logic sof);
    int unsigned      bpp, len, x, slot;
    logic [ByteW-1:0] a, b, c, v;
    logic             row_done;
    if (sof) begin
      col_pos    = 0;
      top_row    = 1'b1;
      filter_err = 1'b0;
    end
    // Latch the filter type at the head of a row
    if (col_pos == 0) begin
      cur_filter = din;
      if (din > FiltPaeth) filter_err = 1'b1;
      col_pos = 1;
      return;
    end
    bpp = (reg_bpp == 0) ? 1 : (reg_bpp > MaxPixelBytes) ? MaxPixelBytes : reg_bpp;
    len = (reg_len == 0) ? 1 : (reg_len > MaxRowBytes) ? MaxRowBytes : reg_len;
    x = col_pos - 1;
    if (x >= MaxRowBytes) x = MaxRowBytes - 1;
    slot = x % bpp;
    a = (x >= bpp) ? left_px[slot] : '0;
    b = top_row ? '0 : prev_row[x];
    c = (!top_row && x >= bpp) ? upleft_px[slot] : '0;
    case (cur_filter)
      FiltNone:  v = din;
      FiltSub:   v = din + a;
      FiltUp:    v = din + b;
      FiltAvg:   v = din + ByteW'((9'(a) + 9'(b)) >> 1);
      FiltPaeth: v = din + paeth_choice(a, b, c);
      default:   v = din;
    endcase
    left_px[slot]   = v;
    upleft_px[slot] = b;
    prev_row[x]     = v;
    if (x + 1 > prev_row_valid) prev_row_valid = x + 1;
    row_done = (x + 1 >= len);
    if (row_done) begin
      col_pos = 0;
      top_row = 1'b0;
    end else begin
      col_pos = x + 2;
    end
    pixels_due.push_back('{pixel: v, row_end: row_done, bad_filter: filter_err});
  endtask

  // --------------------------------------------------------------------------
  // Result check
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected result beat: out_byte %02h row_end %0b", out_byte_o, row_end_o);
        fail_count++;
      end else begin
        beat_due = pixels_due.pop_front();
        if (out_byte_o !== beat_due.pixel) begin
          $error("out_byte: expected %02h, actual %02h", beat_due.pixel, out_byte_o);
          fail_count++;
        end
        if (row_end_o !== beat_due.row_end) begin
          $error("row_end: expected %0b, actual %0b", beat_due.row_end, row_end_o);
          fail_count++;
        end
        if (bad_filter_o !== beat_due.bad_filter) begin
          $error("bad_filter: expected %0b, actual %0b", beat_due.bad_filter, bad_filter_o);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a long hold-off on request
  // --------------------------------------------------------------------------

  initial begin
    out_ready_i  = 1'b0;
    hold_left    = 0;
    rx_mode      = RxFree;
    rx_mode_left = 0;
    rx_tick      = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_e'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
          RxFree:  out_ready_i <= 1'b1;
          RxCoin:  out_ready_i <= ($urandom_range(0, 3) != 0);
          RxComb:  out_ready_i <= (rx_tick % 7 != 3) && (rx_tick % 5 != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender and configuration tasks
  // --------------------------------------------------------------------------

  // Offer one beat and hold it until accepted
  task automatic send_byte(input logic [ByteW-1:0] din, input logic sof);
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    in_byte_i        <= din;
    first_of_image_i <= sof;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(din, sof);
  endtask

  // Insert a random gap at the end of a burst
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
  endtask

  // Send n data bytes, byte i taken from bits [8i+7:8i]
  task automatic send_data(input int n, input logic [63:0] pack);
    for (int i = 0; i < n; i++) begin
      send_byte(pack[8*i +: 8], 1'b0);
      pace();
    end
  endtask

  task automatic send_row(input logic [ByteW-1:0] filt, input logic sof, input int n,
                          input logic [63:0] pack);
    send_byte(filt, sof);
    pace();
    send_data(n, pack);
  endtask

  // Drop valid, wait out all results and the pipeline
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] word);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgBpp) reg_bpp = word[BppW-1:0];
    else if (idx == CfgRowBytes) reg_len = word[LenW-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random beat that never reads an unwritten line store column
  task automatic stream_byte(input logic [ByteW-1:0] din, input logic sof);
    if (reads_unwritten(sof)) sof = 1'b1;
    send_byte(din, sof);
    pace();
  endtask

  function automatic logic [BppW-1:0] pick_bpp();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return BppW'(MaxPixelBytes);
      2:       return BppW'($urandom_range(9, 15));
      default: return BppW'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CfgDataW'(1);
      7, 8:    return CfgDataW'($urandom_range(13, 40));
      9:       return CfgDataW'($urandom_range(41, 160));
      default: return CfgDataW'($urandom_range(2, 12));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: one-byte rows, one byte per pixel
  task automatic test_reset_values();
    send_row(FiltNone, 1'b1, 1, 64'hA5);
    send_row(FiltSub,  1'b0, 1, 64'hFF);
    send_row(FiltUp,   1'b0, 1, 64'h01);
  endtask

  // Each filter type over extreme byte values
  task automatic test_filter_kinds();
    cfg_write(CfgRowBytes, CfgDataW'(3));
    send_row(FiltNone,  1'b1, 3, 64'h80FF00);
    send_row(FiltSub,   1'b0, 3, 64'h7F01FF);
    send_row(FiltUp,    1'b0, 3, 64'h00FF01);
    send_row(FiltAvg,   1'b0, 3, 64'h01FFFF);
    send_row(FiltPaeth, 1'b0, 3, 64'hFF7F80);
  endtask

  // Unknown filter types pass data through; a new image clears the flag
  task automatic test_bad_filter();
    send_row(FiltBadTop, 1'b0, 3, 64'h12FF00);
    send_row(FiltBadLow, 1'b0, 3, 64'h3400FF);
    send_row(FiltUp,     1'b1, 3, 64'h5601AB);
  endtask

  // Out-of-range register values: zero and above the maximum
  task automatic test_register_limits();
    cfg_write(CfgBpp, 14'h3FF0);
    cfg_write(CfgRowBytes, CfgDataW'(5));
    send_row(FiltSub, 1'b1, 5, 64'hFF80017F00);
    cfg_write(CfgBpp, CfgDataW'(15));
    send_row(FiltPaeth, 1'b0, 5, 64'h00FF10EF80);
    cfg_write(CfgRowBytes, '0);
    send_row(FiltAvg, 1'b0, 1, 64'hC3);
  endtask

  // Row length shrunk and grown in the middle of a row
  task automatic test_midrow_change();
    cfg_write(CfgBpp, CfgDataW'(2));
    cfg_write(CfgRowBytes, CfgDataW'(8));
    send_row(FiltSub, 1'b1, 5, 64'h0102FFFE80);
    cfg_write(CfgRowBytes, CfgDataW'(3));
    send_data(1, 64'h55);
    send_row(FiltUp, 1'b0, 2, 64'hAA01);
    cfg_write(CfgRowBytes, CfgDataW'(6));
    send_data(4, 64'h0FF0807F);
  endtask

  // Hold off the receiver while the sender keeps offering beats
  task automatic test_backpressure();
    cfg_write(CfgBpp, CfgDataW'(3));
    cfg_write(CfgRowBytes, CfgDataW'(7));
    hold_req = 1'b1;
    for (int r = 0; r < 10; r++) begin
      send_byte(ByteW'(r % 5), r == 0);
      repeat (7) send_byte(ByteW'($urandom), 1'b0);
    end
  endtask

  // Long row with the pixel size at its maximum and the row length register above its maximum; the row stays open
  task automatic test_max_row();
    cfg_write(CfgBpp, 14'h3FF8);
    cfg_write(CfgRowBytes, 14'h3FFF);
    send_byte(FiltSub, 1'b1);
    pace();
    repeat (LongRowBytes) begin
      send_byte(ByteW'($urandom), 1'b0);
      pace();
    end
  endtask

  // Mostly well-formed rows with random content, some cut short or restarted
  task automatic test_random_stream();
    int unsigned         sent, phase;
    logic [CfgDataW-1:0] word;
    logic [ByteW-1:0]    filt;
    logic                sof;
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      if (phase == 0 || $urandom_range(0, 2) == 0) begin
        word = CfgDataW'($urandom);
        word[BppW-1:0] = pick_bpp();
        cfg_write(CfgBpp, word);
      end
      if (phase == 0 || $urandom_range(0, 2) == 0) cfg_write(CfgRowBytes, pick_len());
      repeat ($urandom_range(1, 6)) begin
        sof  = ($urandom_range(0, 4) == 0);
        filt = ($urandom_range(0, 11) == 0) ? ByteW'($urandom_range(5, 255))
                                            : ByteW'($urandom_range(0, 4));
        stream_byte(filt, sof);
        sent++;
        // Fill the row; now and then cut it short or restart the image
        while (col_pos != 0) begin
          if ($urandom_range(0, 79) == 0) break;
          stream_byte(ByteW'($urandom), $urandom_range(0, 99) == 0);
          sent++;
        end
      end
      phase++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CfgBpp;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    in_byte_i        = '0;
    first_of_image_i = 1'b0;
    hold_req         = 1'b0;
    fail_count       = 0;
    burst_left       = 0;
    foreach (prev_row[i]) prev_row[i] = '0;
    foreach (left_px[i]) begin
      left_px[i]   = '0;
      upleft_px[i] = '0;
    end
    col_pos        = 0;
    prev_row_valid = 0;
    cur_filter     = FiltNone;
    top_row        = 1'b1;
    filter_err     = 1'b0;
    reg_bpp        = BppW'(1);
    reg_len        = LenW'(1);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_filter_kinds();
    test_bad_filter();
    test_register_limits();
    test_midrow_change();
    test_backpressure();
    test_max_row();
    test_random_stream();
    settle();

    if (fail_count == 0 && pixels_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/psu_pkg.sv
hw/rtl/psu_ram.sv
hw/rtl/psu_ctrl.sv
hw/rtl/psu_recon.sv
hw/rtl/png_scanline_unfilter.sv
test/testbench.sv
